FILE: rtl/frm_pkg.sv
// Shared constants and the sequencer state type for the fraction reducer.
`default_nettype none

package frm_pkg;

    // Default operand width
    localparam int FRM_WIDTH = 16;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_GCD   = 6'b000010,
        S_DIV_N = 6'b000100,
        S_DIV_D = 6'b001000,
        S_DIV_W = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

endpackage : frm_pkg

`default_nettype wire

FILE: rtl/fraction_reduce_mixed.sv
// Fraction reducer: binary gcd, reduction and mixed-number split on one shared subtractor.
//
//  channel   | dir | handshake                 | payload
//  ----------+-----+---------------------------+------------------------------------------
//  s (input) | in  | i_s_tvalid / o_s_tready   | i_s_tdata: numerator, denominator
//  m (output)| out | o_m_tvalid / i_m_tready   | o_m_tdata: rn, rd, whole, remainder;
//            |     |                           | o_m_tuser: has_whole, zero_denominator
//
// A request goes from idle through the binary gcd loop, the three restoring divisions and
// the output state back to idle; a zero denominator goes from idle straight to the output
// state. The single (WIDTH+1)-bit subtractor is shared by the gcd loop and the three
// restoring divisions of one bit per cycle. A new request is not taken until the last result
// has been taken: o_s_tready is high only when idle.
// A result is held on o_m_tdata/o_m_tuser until i_m_tready takes it.
// i_rst_n is synchronous, active low, and returns the sequencer to idle.
`default_nettype none

module fraction_reduce_mixed
    import frm_pkg::*;
#(
    parameter int WIDTH = FRM_WIDTH
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // slave side
    input  wire logic                                 i_s_tvalid,
    output logic                                      o_s_tready,
    // [WIDTH-1:0] numerator, [2*WIDTH-1:WIDTH] denominator, zero pad to bytes
    input  wire logic [((2*WIDTH+7)/8)*8-1:0]         i_s_tdata,
    // master side
    output logic                                      o_m_tvalid,
    input  wire logic                                 i_m_tready,
    // reduced_numerator, reduced_denominator, whole_part, remainder_numerator
    // (WIDTH bits each, lowest first), zero pad to bytes
    output logic [((4*WIDTH+7)/8)*8-1:0]              o_m_tdata,
    // [0] has_whole, [1] zero_denominator
    output logic [1:0]                                o_m_tuser
);

    localparam int MDW = ((4*WIDTH+7)/8)*8;
    localparam int CW  = $clog2(WIDTH);

    // Sequencer and working registers
    t_state           r_state, n_state;
    logic [WIDTH-1:0] r_a, n_a;         // gcd operand; dividend not used here
    logic [WIDTH-1:0] r_b, n_b;         // gcd operand, then divisor
    logic [WIDTH-1:0] r_n, n_n;         // numerator scaled by common powers of two
    logic [WIDTH-1:0] r_d, n_d;         // denominator scaled likewise
    logic [WIDTH-1:0] r_rem, n_rem;     // partial remainder
    logic [WIDTH-1:0] r_quo, n_quo;     // dividend shifting out, quotient shifting in
    logic [CW-1:0]    r_cnt, n_cnt;     // division bit counter

    // Result registers
    logic [WIDTH-1:0] r_rn, n_rn;
    logic [WIDTH-1:0] r_rd, n_rd;
    logic [WIDTH-1:0] r_whole, n_whole;
    logic [WIDTH-1:0] r_remn, n_remn;
    logic             r_hw, n_hw;
    logic             r_zd, n_zd;

    // Shared subtractor
    logic [WIDTH:0]   sub_a;
    logic [WIDTH:0]   sub_b;
    logic [WIDTH+1:0] diff;
    logic             borrow;
    logic [WIDTH-1:0] rem_step;
    logic [WIDTH-1:0] quo_step;
    logic             last_bit;

    logic [WIDTH-1:0] in_num;
    logic [WIDTH-1:0] in_den;

    assign in_num = i_s_tdata[WIDTH-1:0];
    assign in_den = i_s_tdata[2*WIDTH-1:WIDTH];

    // Select subtractor operands: gcd compare or division trial
    always_comb begin
        if (r_state == S_GCD) begin
            sub_a = {1'b0, r_a};
            sub_b = {1'b0, r_b};
        end else begin
            sub_a = {r_rem, r_quo[WIDTH-1]};
            sub_b = {1'b0, r_b};
        end
    end

    assign diff     = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow   = diff[WIDTH+1];
    assign rem_step = borrow ? sub_a[WIDTH-1:0] : diff[WIDTH-1:0];
    assign quo_step = {r_quo[WIDTH-2:0], ~borrow};
    assign last_bit = (r_cnt == CW'(WIDTH-1));

    // Sequence the gcd and the three divisions
    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_n     = r_n;
        n_d     = r_d;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_rn    = r_rn;
        n_rd    = r_rd;
        n_whole = r_whole;
        n_remn  = r_remn;
        n_hw    = r_hw;
        n_zd    = r_zd;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_a = in_num;
                    n_b = in_den;
                    n_n = in_num;
                    n_d = in_den;
                    if (in_den == '0) begin
                        n_rn    = '0;
                        n_rd    = '0;
                        n_whole = '0;
                        n_remn  = '0;
                        n_hw    = 1'b0;
                        n_zd    = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_zd    = 1'b0;
                        n_state = S_GCD;
                    end
                end
            end
            S_GCD: begin
                if (r_a == '0) begin
                    // gcd odd part found in r_b; divide the scaled numerator
                    n_rem   = '0;
                    n_quo   = r_n;
                    n_cnt   = '0;
                    n_state = S_DIV_N;
                end else if (!r_a[0] && !r_b[0]) begin
                    // drop a common factor of two from all operands
                    n_a = r_a >> 1;
                    n_b = r_b >> 1;
                    n_n = r_n >> 1;
                    n_d = r_d >> 1;
                end else if (!r_a[0]) begin
                    n_a = r_a >> 1;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (borrow) begin
                    // keep the larger odd value in r_a
                    n_a = r_b;
                    n_b = r_a;
                end else begin
                    // odd minus odd is even: subtract and halve
                    n_a = diff[WIDTH:1];
                end
            end
            S_DIV_N: begin
                n_rem = rem_step;
                n_quo = quo_step;
                n_cnt = r_cnt + 1'b1;
                if (last_bit) begin
                    n_rn    = quo_step;
                    n_rem   = '0;
                    n_quo   = r_d;
                    n_cnt   = '0;
                    n_state = S_DIV_D;
                end
            end
            S_DIV_D: begin
                n_rem = rem_step;
                n_quo = quo_step;
                n_cnt = r_cnt + 1'b1;
                if (last_bit) begin
                    // reduced denominator becomes the next divisor
                    n_rd    = quo_step;
                    n_b     = quo_step;
                    n_rem   = '0;
                    n_quo   = r_rn;
                    n_cnt   = '0;
                    n_state = S_DIV_W;
                end
            end
            S_DIV_W: begin
                n_rem = rem_step;
                n_quo = quo_step;
                n_cnt = r_cnt + 1'b1;
                if (last_bit) begin
                    // a zero quotient means a proper fraction, remainder is rn
                    n_whole = quo_step;
                    n_remn  = rem_step;
                    n_hw    = |quo_step;
                    n_cnt   = '0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_b     <= n_b;
        r_n     <= n_n;
        r_d     <= n_d;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_rn    <= n_rn;
        r_rd    <= n_rd;
        r_whole <= n_whole;
        r_remn  <= n_remn;
        r_hw    <= n_hw;
        r_zd    <= n_zd;
    end

    // Drive the ports
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_OUT);
    assign o_m_tdata  = MDW'({r_remn, r_whole, r_rd, r_rn});
    assign o_m_tuser  = {r_zd, r_hw};

`ifndef SYNTHESIS
    // An error result carries all-zero fields
    a_zd_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_zd) |->
            (r_rn == '0 && r_rd == '0 && r_whole == '0 && r_remn == '0 && !r_hw))
        else $error("zero denominator result with nonzero fields");

    // A good result has a proper remainder below a nonzero denominator
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !r_zd) |-> (r_rd != '0 && r_remn < r_rd))
        else $error("remainder not below reduced denominator");

    // The gcd loop never sees a zero in its second operand
    a_gcd_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GCD) |-> (r_b != '0))
        else $error("gcd divisor operand is zero");

    // A request with a nonzero denominator never shows a result in the next cycle
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && in_den != '0) |=> !o_m_tvalid)
        else $error("result shown too early");

    // The division counter only runs during divisions
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_GCD || r_state == S_OUT) |-> (r_cnt == '0))
        else $error("division counter not cleared");
`endif

endmodule : fraction_reduce_mixed

`default_nettype wire
